>>> rtl/qpc_pkg.sv
package qpc_pkg;

  localparam int unsigned SampleWidth = 10;
  localparam int unsigned LimitWidth  = 15;
  localparam int unsigned CountWidth  = 16;
  localparam int unsigned CfgDataWidth = 15;

  localparam logic [SampleWidth-1:0] ThresholdReset = 10'd511;
  localparam logic [LimitWidth-1:0]  LimitReset     = 15'd10000;

  typedef enum logic [1:0] {
    REG_INVERT    = 2'd0,
    REG_THRESHOLD = 2'd1,
    REG_LIMIT     = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                   invert;
    logic [SampleWidth-1:0] threshold;
    logic [LimitWidth-1:0]  limit;
  } cfg_t;

  typedef struct packed {
    logic                   opcode;
    logic [SampleWidth-1:0] sample_a;
    logic [SampleWidth-1:0] sample_b;
  } item_t;

  typedef struct packed {
    logic signed [CountWidth-1:0] position;
    logic                         limit_reset;
  } result_t;

endpackage

>>> rtl/qpc_if.sv
interface qpc_in_if;
  logic                                valid;
  logic                                ready;
  logic                                opcode;
  logic [qpc_pkg::SampleWidth-1:0]     sample_a;
  logic [qpc_pkg::SampleWidth-1:0]     sample_b;

  modport source (output valid, output opcode, output sample_a, output sample_b,
                  input ready);
  modport sink   (input valid, input opcode, input sample_a, input sample_b,
                  output ready);
endinterface

interface qpc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [qpc_pkg::CountWidth-1:0] position;
  logic                                limit_reset;

  modport source (output valid, output position, output limit_reset, input ready);
  modport sink   (input valid, input position, input limit_reset, output ready);
endinterface

interface qpc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          index;
  logic [qpc_pkg::CfgDataWidth-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/qpc_cfg_regs.sv
module qpc_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  qpc_cfg_if.sink          cfg_ch,
  output qpc_pkg::cfg_t    cfg
);

  qpc_pkg::cfg_t cfg_r;
  qpc_pkg::cfg_t cfg_nxt;
  qpc_pkg::cfg_reg_t idx;

  assign cfg_ch.ready = 1'b1;
  assign idx = qpc_pkg::cfg_reg_t'(cfg_ch.index);

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (idx)
        qpc_pkg::REG_INVERT:    cfg_nxt.invert    = cfg_ch.data[0];
        qpc_pkg::REG_THRESHOLD: cfg_nxt.threshold = cfg_ch.data[qpc_pkg::SampleWidth-1:0];
        qpc_pkg::REG_LIMIT:     cfg_nxt.limit     = cfg_ch.data[qpc_pkg::LimitWidth-1:0];
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.invert    <= 1'b0;
      cfg_r.threshold <= qpc_pkg::ThresholdReset;
      cfg_r.limit     <= qpc_pkg::LimitReset;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/qpc_count.sv
module qpc_count (
  input  logic             clk,
  input  logic             rst_n,
  input  qpc_pkg::cfg_t    cfg,
  input  logic             advance,
  input  qpc_pkg::item_t   item,
  output qpc_pkg::result_t result
);

  localparam int unsigned SumWidth = qpc_pkg::CountWidth + 1;

  logic                                last_a_r, last_a_nxt;
  logic                                last_b_r, last_b_nxt;
  logic signed [qpc_pkg::CountWidth-1:0] count_r, count_nxt;

  logic                        a_hi, b_hi;
  logic                        a_chg, b_chg;
  logic                        a_up, b_up;
  logic signed [SumWidth-1:0]  lim_s;
  logic signed [SumWidth-1:0]  cnt0;
  logic [SumWidth:0]           step_a, step_b;
  logic signed [SumWidth-1:0]  cnt1, cnt2;
  logic                        hit;

  // One step of plus or minus one; the top bit of the result flags a limit reset.
  function automatic logic [SumWidth:0] apply_step(input logic signed [SumWidth-1:0] c,
                                                   input logic up,
                                                   input logic signed [SumWidth-1:0] lim);
    logic signed [SumWidth-1:0] s;
    logic                       over;
    s    = up ? (c + SumWidth'(1)) : (c - SumWidth'(1));
    over = (s > lim) || (s < -lim);
    return over ? {1'b1, {SumWidth{1'b0}}} : {1'b0, s};
  endfunction

  assign a_hi  = item.sample_a > cfg.threshold;
  assign b_hi  = item.sample_b > cfg.threshold;
  assign a_chg = a_hi != last_a_r;
  assign b_chg = b_hi != last_b_r;

  // The B rule looks at A from the previous sample, even when A moved too.
  assign a_up  = ~(a_hi ^ last_b_r) ^ cfg.invert;
  assign b_up  = (b_hi ^ last_a_r) ^ cfg.invert;

  assign lim_s = $signed({2'b00, cfg.limit});
  assign cnt0  = SumWidth'(count_r);

  assign step_a = apply_step(cnt0, a_up, lim_s);
  assign cnt1   = a_chg ? $signed(step_a[SumWidth-1:0]) : cnt0;
  assign step_b = apply_step(cnt1, b_up, lim_s);
  assign cnt2   = b_chg ? $signed(step_b[SumWidth-1:0]) : cnt1;

  always_comb begin
    last_a_nxt = last_a_r;
    last_b_nxt = last_b_r;
    count_nxt  = count_r;
    hit        = 1'b0;
    if (item.opcode == qpc_pkg::OP_CLEAR) begin
      count_nxt = '0;
    end else begin
      last_a_nxt = a_hi;
      last_b_nxt = b_hi;
      count_nxt  = cnt2[qpc_pkg::CountWidth-1:0];
      hit        = (a_chg && step_a[SumWidth]) || (b_chg && step_b[SumWidth]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_a_r <= 1'b0;
      last_b_r <= 1'b0;
      count_r  <= '0;
    end else if (advance) begin
      last_a_r <= last_a_nxt;
      last_b_r <= last_b_nxt;
      count_r  <= count_nxt;
    end
  end

  assign result.position    = count_nxt;
  assign result.limit_reset = hit;

endmodule

>>> rtl/quadrature_position_counter_top.sv
// Quadrature position counter with x4 decoding. Each input beat is either a pair of
// 10-bit channel samples, compared against the threshold register, or a clear command;
// each produces exactly one result beat carrying the signed count and a flag that is set
// when the count passed the limit and was returned to zero. While the sink keeps taking
// results, the block takes one beat per clock cycle: a beat is held in an item register,
// and the count is updated as it moves into the result register. While a finished result
// waits for the sink, the item register can still take one more beat; after that the
// input stalls until the result is taken. Configuration writes are always accepted and
// must only be issued while no beats are in flight.
module quadrature_position_counter_top (
  input  logic       clk,
  input  logic       rst_n,
  qpc_in_if.sink     in_ch,
  qpc_out_if.source  out_ch,
  qpc_cfg_if.sink    cfg_ch
);

  qpc_pkg::cfg_t    cfg;
  qpc_pkg::item_t   item_r, item_in;
  qpc_pkg::result_t result_r, result;
  logic             item_vld_r, item_vld_nxt;
  logic             out_vld_r, out_vld_nxt;
  logic             advance;
  logic             in_accept;

  qpc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  qpc_count u_count (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .advance (advance),
    .item    (item_r),
    .result  (result)
  );

  assign advance      = item_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !item_vld_r || advance;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign item_vld_nxt = in_accept || (item_vld_r && !advance);
  assign out_vld_nxt  = advance || (out_vld_r && !out_ch.ready);

  assign item_in.opcode   = in_ch.opcode;
  assign item_in.sample_a = in_ch.sample_a;
  assign item_in.sample_b = in_ch.sample_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= item_in;
    end
    if (advance) begin
      result_r <= result;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.position    = result_r.position;
  assign out_ch.limit_reset = result_r.limit_reset;

endmodule

>>> sim/tb_top.sv
module tb_top;
  import qpc_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int PhaseCount  = 9;
  localparam int PhaseItems  = 150;
  localparam int HoldCycles  = 80;
  localparam int SettleCycles = 4;

  // Tracks the expected count and compares each result beat against it.
  class position_scoreboard;
    logic                   invert;
    logic [SampleWidth-1:0] threshold;
    logic [LimitWidth-1:0]  limit;
    logic                   last_a;
    logic                   last_b;
    int                     count;
    result_t                pending_q[$];
    int                     errors;

    function new();
      invert    = 1'b0;
      threshold = ThresholdReset;
      limit     = LimitReset;
      last_a    = 1'b0;
      last_b    = 1'b0;
      count     = 0;
      errors    = 0;
    endfunction

    function void set_register(cfg_reg_t idx, logic [CfgDataWidth-1:0] data);
      case (idx)
        REG_INVERT:    invert = data[0];
        REG_THRESHOLD: threshold = data[SampleWidth-1:0];
        REG_LIMIT:     limit = data[LimitWidth-1:0];
        default: ;
      endcase
    endfunction

    // One count step; returns 1 when the limit returned the count to zero.
    function bit take_step(bit up);
      if (invert) up = !up;
      count += up ? 1 : -1;
      if (count > int'(limit) || count < -int'(limit)) begin
        count = 0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_item(item_t it);
      result_t want;
      bit      a;
      bit      b;
      bit      hit;
      hit = 1'b0;
      if (it.opcode == OP_CLEAR) begin
        count = 0;
      end else begin
        a = it.sample_a > threshold;
        b = it.sample_b > threshold;
        // The B step looks at the level of A from the previous sample.
        if (a != last_a) hit |= take_step(a == last_b);
        if (b != last_b) hit |= take_step(b != last_a);
        last_a = a;
        last_b = b;
      end
      want.position    = count[CountWidth-1:0];
      want.limit_reset = hit;
      pending_q.push_back(want);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_q.size() == 0) begin
        $error("result beat with nothing outstanding: position %0d, limit_reset %0b",
               got.position, got.limit_reset);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.position !== want.position) begin
        $error("position mismatch: expected %0d, actual %0d", want.position, got.position);
        errors++;
      end
      if (got.limit_reset !== want.limit_reset) begin
        $error("limit_reset mismatch: expected %0b, actual %0b",
               want.limit_reset, got.limit_reset);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  qpc_in_if  in_bus ();
  qpc_out_if out_bus ();
  qpc_cfg_if cfg_bus ();

  quadrature_position_counter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  position_scoreboard     sb;
  int                     cycle_count;
  bit                     quiet;
  bit                     hold_request;
  logic [SampleWidth-1:0] cur_threshold;
  bit                     lvl_a;
  bit                     lvl_b;
  bit                     walk_up;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      sb.check_result(result_t'{out_bus.position, out_bus.limit_reset});
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Receiver side: random stalls, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_bus.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_request = 1'b0;
      end else if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Leaves valid high on return; the next call or drain_results moves it on.
  task automatic send_item(item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid    <= 1'b1;
    in_bus.opcode   <= it.opcode;
    in_bus.sample_a <= it.sample_a;
    in_bus.sample_b <= it.sample_b;
    do @(posedge clk); while (!in_bus.ready);
    sb.note_item(it);
  endtask

  task automatic send_pair(opcode_t op, int a, int b);
    item_t it;
    it.opcode   = op;
    it.sample_a = a[SampleWidth-1:0];
    it.sample_b = b[SampleWidth-1:0];
    send_item(it);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_t idx, int value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value[CfgDataWidth-1:0];
    do @(posedge clk); while (!cfg_bus.ready);
    sb.set_register(idx, value[CfgDataWidth-1:0]);
    if (idx == REG_THRESHOLD) cur_threshold = value[SampleWidth-1:0];
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [SampleWidth-1:0] level_sample(bit lvl);
    if (!lvl) return SampleWidth'($urandom_range(int'(cur_threshold), 0));
    if (cur_threshold != '1) return SampleWidth'($urandom_range(1023, int'(cur_threshold) + 1));
    return '1;
  endfunction

  // Mostly clean quadrature walks, with clears, double changes and raw noise mixed in.
  task automatic send_random_item();
    item_t it;
    int    r;
    r = $urandom_range(0, 99);
    it.opcode = OP_SAMPLE;
    if (r < 5) begin
      it.opcode   = OP_CLEAR;
      it.sample_a = SampleWidth'($urandom);
      it.sample_b = SampleWidth'($urandom);
    end else if (r < 15) begin
      it.sample_a = SampleWidth'($urandom);
      it.sample_b = SampleWidth'($urandom);
      lvl_a = it.sample_a > cur_threshold;
      lvl_b = it.sample_b > cur_threshold;
    end else begin
      if (r < 25) begin
        lvl_a = $urandom_range(0, 1);
        lvl_b = $urandom_range(0, 1);
      end else begin
        if ($urandom_range(0, 9) == 0) walk_up = !walk_up;
        if ((lvl_a == lvl_b) == walk_up) lvl_a = !lvl_a;
        else lvl_b = !lvl_b;
      end
      it.sample_a = level_sample(lvl_a);
      it.sample_b = level_sample(lvl_b);
    end
    send_item(it);
  endtask

  initial begin
    int thr;
    int lim;
    sb            = new();
    cycle_count   = 0;
    quiet         = 1'b0;
    hold_request  = 1'b0;
    cur_threshold = ThresholdReset;
    lvl_a         = 1'b0;
    lvl_b         = 1'b0;
    walk_up       = 1'b1;
    rst_n           = 1'b0;
    in_bus.valid    = 1'b0;
    in_bus.opcode   = OP_SAMPLE;
    in_bus.sample_a = '0;
    in_bus.sample_b = '0;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = REG_INVERT;
    cfg_bus.data    = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Full cycle backwards and forwards at the reset settings, then the edges.
    send_pair(OP_CLEAR, 1023, 1023);
    send_pair(OP_SAMPLE, 0, 0);
    send_pair(OP_SAMPLE, 1023, 0);
    send_pair(OP_SAMPLE, 1023, 1023);
    send_pair(OP_SAMPLE, 0, 1023);
    send_pair(OP_SAMPLE, 0, 0);
    send_pair(OP_SAMPLE, 0, 512);
    send_pair(OP_SAMPLE, 512, 512);
    send_pair(OP_SAMPLE, 512, 0);
    send_pair(OP_SAMPLE, 0, 0);
    send_pair(OP_SAMPLE, 511, 511);
    send_pair(OP_SAMPLE, 1023, 1023);
    send_pair(OP_SAMPLE, 0, 0);
    send_pair(OP_CLEAR, 1023, 0);
    drain_results();
    repeat (SettleCycles) @(posedge clk);

    // Inverted direction with the tightest limit, so every second step of the walk resets.
    write_register(REG_INVERT, 1);
    write_register(REG_LIMIT, 1);
    write_register(REG_THRESHOLD, 0);
    send_pair(OP_SAMPLE, 1, 0);
    send_pair(OP_SAMPLE, 1, 1);
    send_pair(OP_SAMPLE, 0, 1);
    send_pair(OP_SAMPLE, 0, 0);
    send_pair(OP_SAMPLE, 1023, 1023);
    send_pair(OP_CLEAR, 0, 0);

    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      repeat (SettleCycles) @(posedge clk);
      case (p)
        2: thr = 0;
        5: thr = 1023;
        7: thr = 511;
        default: thr = $urandom_range(0, 1023);
      endcase
      case (p)
        3: lim = 1;
        6: lim = 32766;
        8: lim = LimitReset;
        default: lim = $urandom_range(2, 60);
      endcase
      write_register(REG_INVERT, p % 2);
      write_register(REG_THRESHOLD, thr);
      write_register(REG_LIMIT, lim);
      quiet = (p % 3 == 1);
      if (p == 2) hold_request = 1'b1;
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 4 && i == PhaseItems / 2) drain_results();
        send_random_item();
      end
    end

    drain_results();
    repeat (SettleCycles + 2) @(posedge clk);
    if (sb.pending_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_q.size());
    end
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
